@@ hw/rtl/ytc_pkg.sv @@
// Shared types, field widths, register codes and reset values of the yaw tracking controller.
package ytc_pkg;

  localparam int YTC_TIME_BITS_DEF  = 48;
  localparam int YTC_PIXEL_BITS_DEF = 12;

  // Configuration register widths.
  localparam int YTC_CENTER_W  = 12;
  localparam int YTC_RATIO_W   = 16;
  localparam int YTC_GAIN_W    = 24;
  localparam int YTC_LIMIT_W   = 23;
  localparam int YTC_UPPER_W   = 15;
  localparam int YTC_LOWER_W   = 16;
  localparam int YTC_TIMEOUT_W = 32;
  localparam int YTC_SCALE_W   = 32;
  localparam int YTC_CFG_DATA_W = 32;
  localparam int YTC_CFG_IDX_W  = 3;

  // Result widths.
  localparam int YTC_RATE_W  = 24;
  localparam int YTC_ANGLE_W = 16;

  // Serial multiplier datapath.
  localparam int YTC_PROD_W  = YTC_LIMIT_W + YTC_SCALE_W;
  localparam int YTC_ACC_W   = 60;
  localparam logic [YTC_ACC_W-1:0] YTC_PROD_CAP = YTC_ACC_W'(1) << 58;

  // Angle step: rounding point, saturated step and the adder width.
  localparam int YTC_STEP_SHIFT = 40;
  localparam int YTC_DELTA_W    = 19;
  localparam int YTC_ANG_SUM_W  = 21;
  localparam int YTC_GAIN_SHIFT = 8;

  // Reset values of the configuration registers.
  localparam logic [YTC_CENTER_W-1:0]  YTC_CENTER_RST  = 12'd320;
  localparam logic [YTC_RATIO_W-1:0]   YTC_RATIO_RST   = 16'd6554;
  localparam logic [YTC_GAIN_W-1:0]    YTC_GAIN_RST    = 24'd33554;
  localparam logic [YTC_LIMIT_W-1:0]   YTC_LIMIT_RST   = 23'd65536;
  localparam logic [YTC_UPPER_W-1:0]   YTC_UPPER_RST   = 15'd23040;
  localparam logic [YTC_LOWER_W-1:0]   YTC_LOWER_RST   = 16'hA600;
  localparam logic [YTC_TIMEOUT_W-1:0] YTC_TIMEOUT_RST = 32'd500000;
  localparam logic [YTC_SCALE_W-1:0]   YTC_SCALE_RST   = 32'd246083;

  typedef enum logic [YTC_CFG_IDX_W-1:0] {
    CFG_IMAGE_CENTER   = 3'd0,
    CFG_DEADBAND_RATIO = 3'd1,
    CFG_RATE_GAIN      = 3'd2,
    CFG_RATE_LIMIT     = 3'd3,
    CFG_ANGLE_UPPER    = 3'd4,
    CFG_ANGLE_LOWER    = 3'd5,
    CFG_GOAL_TIMEOUT   = 3'd6,
    CFG_DEGREE_SCALE   = 3'd7
  } ytc_cfg_idx_t;

  typedef enum logic {
    OP_SIGHTING = 1'b0,
    OP_TICK     = 1'b1
  } ytc_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_BAND,
    ST_GAIN,
    ST_TICK,
    ST_STEP,
    ST_PROD,
    ST_TICK_END,
    ST_OUT
  } ytc_state_t;

  typedef struct packed {
    logic [YTC_CENTER_W-1:0]        image_center;
    logic [YTC_RATIO_W-1:0]         deadband_ratio;
    logic [YTC_GAIN_W-1:0]          rate_gain;
    logic [YTC_LIMIT_W-1:0]         rate_limit;
    logic [YTC_UPPER_W-1:0]         angle_upper;
    logic signed [YTC_LOWER_W-1:0]  angle_lower;
    logic [YTC_TIMEOUT_W-1:0]       goal_timeout;
    logic [YTC_SCALE_W-1:0]         degree_scale;
  } ytc_cfg_t;

endpackage

@@ hw/rtl/ytc_cfg_regs.sv @@
// Configuration register file with index decode and reset values.
module ytc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write_en,
  input  logic [ytc_pkg::YTC_CFG_IDX_W-1:0]   cfg_index,
  input  logic [ytc_pkg::YTC_CFG_DATA_W-1:0]  cfg_data,
  output ytc_pkg::ytc_cfg_t                   cfg
);
  import ytc_pkg::*;

  ytc_cfg_t cfg_r;
  ytc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      case (ytc_cfg_idx_t'(cfg_index))
        CFG_IMAGE_CENTER:   cfg_nxt.image_center   = cfg_data[YTC_CENTER_W-1:0];
        CFG_DEADBAND_RATIO: cfg_nxt.deadband_ratio = cfg_data[YTC_RATIO_W-1:0];
        CFG_RATE_GAIN:      cfg_nxt.rate_gain      = cfg_data[YTC_GAIN_W-1:0];
        CFG_RATE_LIMIT:     cfg_nxt.rate_limit     = cfg_data[YTC_LIMIT_W-1:0];
        CFG_ANGLE_UPPER:    cfg_nxt.angle_upper    = cfg_data[YTC_UPPER_W-1:0];
        CFG_ANGLE_LOWER:    cfg_nxt.angle_lower    = $signed(cfg_data[YTC_LOWER_W-1:0]);
        CFG_GOAL_TIMEOUT:   cfg_nxt.goal_timeout   = cfg_data[YTC_TIMEOUT_W-1:0];
        CFG_DEGREE_SCALE:   cfg_nxt.degree_scale   = cfg_data[YTC_SCALE_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_center   <= YTC_CENTER_RST;
      cfg_r.deadband_ratio <= YTC_RATIO_RST;
      cfg_r.rate_gain      <= YTC_GAIN_RST;
      cfg_r.rate_limit     <= YTC_LIMIT_RST;
      cfg_r.angle_upper    <= YTC_UPPER_RST;
      cfg_r.angle_lower    <= $signed(YTC_LOWER_RST);
      cfg_r.goal_timeout   <= YTC_TIMEOUT_RST;
      cfg_r.degree_scale   <= YTC_SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/ytc_serial_mult.sv @@
// Bit-serial shift-add multiplier with a saturation flag for oversized products.
module ytc_serial_mult #(
  parameter int MP_W  = ytc_pkg::YTC_TIME_BITS_DEF,
  parameter int LEN_W = $clog2(MP_W + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [LEN_W-1:0]                  len,
  input  logic [ytc_pkg::YTC_PROD_W-1:0]    mcand,
  input  logic [MP_W-1:0]                   mplier,
  output logic                              busy,
  output logic [ytc_pkg::YTC_ACC_W-1:0]     acc,
  output logic                              sat
);
  import ytc_pkg::*;

  logic [LEN_W-1:0]      cnt_r,    cnt_nxt;
  logic [YTC_PROD_W-1:0] mcand_r,  mcand_nxt;
  logic [MP_W-1:0]       mplier_r, mplier_nxt;
  logic [YTC_ACC_W-1:0]  acc_r,    acc_nxt;
  logic                  sat_r,    sat_nxt;
  logic [YTC_ACC_W-1:0]  step_sum;

  // The multiplier is consumed most significant bit first, so the
  // accumulator only grows and an overflow past the cap is final.
  always_comb begin
    step_sum = {acc_r[YTC_ACC_W-2:0], 1'b0} +
               (mplier_r[MP_W-1] ? YTC_ACC_W'(mcand_r) : '0);
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    sat_nxt    = sat_r;
    if (start) begin
      cnt_nxt    = len;
      mcand_nxt  = mcand;
      mplier_nxt = mplier;
      acc_nxt    = '0;
      sat_nxt    = 1'b0;
    end else if (cnt_r != '0) begin
      cnt_nxt    = cnt_r - 1'b1;
      mplier_nxt = {mplier_r[MP_W-2:0], 1'b0};
      if (!sat_r) begin
        if (step_sum > YTC_PROD_CAP) begin
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = step_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    sat_r    <= sat_nxt;
  end

  assign busy = (cnt_r != '0);
  assign acc  = acc_r;
  assign sat  = sat_r;

endmodule

@@ hw/rtl/yaw_tracking_controller_core.sv @@
// Top level of the yaw tracking controller: sequencer, state registers and result register.
//
// Yaw tracking controller. Each request is a target sighting or a control
// tick, and each produces exactly one result showing rate, angle and goal
// flag after that request. One request is worked on at a time; in_stall is
// high from acceptance until the result has been moved into the output
// register. All products go through one bit-serial shift-add multiplier
// that takes one multiplier bit per cycle, so it sets the latency. A
// sighting runs a deadband product and then, if the error lies outside
// the deadband, a gain product. A tick runs a rate-times-scale product
// and then a product with the elapsed time; the first tick after reset
// skips both. A finished result may wait in the output register under
// out_stall while the next request is accepted and processed.
// Configuration registers are written through cfg_write_en, cfg_index and
// cfg_data and should only be changed while the block is idle.
module yaw_tracking_controller_core #(
  parameter int TIME_BITS  = ytc_pkg::YTC_TIME_BITS_DEF,
  parameter int PIXEL_BITS = ytc_pkg::YTC_PIXEL_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Configuration port.
  input  logic                                    cfg_write_en,
  input  logic [ytc_pkg::YTC_CFG_IDX_W-1:0]       cfg_index,
  input  logic [ytc_pkg::YTC_CFG_DATA_W-1:0]      cfg_data,
  // Request channel.
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_operation,
  input  logic [PIXEL_BITS-1:0]                   in_pixel_x,
  input  logic [PIXEL_BITS-1:0]                   in_box_width,
  input  logic [TIME_BITS-1:0]                    in_time_stamp,
  // Result channel.
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ytc_pkg::YTC_RATE_W-1:0]   out_yaw_rate,
  output logic signed [ytc_pkg::YTC_ANGLE_W-1:0]  out_yaw_angle,
  output logic                                    out_goal_active
);
  import ytc_pkg::*;

  // Pixel error magnitude must hold both the pixel and the center range.
  localparam int MAG_W = (PIXEL_BITS > YTC_CENTER_W) ? PIXEL_BITS : YTC_CENTER_W;
  localparam int ERR_W = MAG_W + 1;
  localparam int LEN_W = $clog2(TIME_BITS + 1);
  localparam int ANG_EXT_W = YTC_ANG_SUM_W - YTC_ANGLE_W;

  ytc_cfg_t cfg;

  ytc_state_t state_r, state_nxt;

  // Captured request.
  logic                  op_r,  op_nxt;
  logic [PIXEL_BITS-1:0] px_r,  px_nxt;
  logic [PIXEL_BITS-1:0] bw_r,  bw_nxt;
  logic [TIME_BITS-1:0]  t_r,   t_nxt;

  // Controller state.
  logic [YTC_RATE_W-1:0]  rate_r,  rate_nxt;
  logic [YTC_ANGLE_W-1:0] angle_r, angle_nxt;
  logic                   goal_r,  goal_nxt;
  logic [TIME_BITS-1:0]   sighting_time_r, sighting_time_nxt;
  logic [TIME_BITS-1:0]   tick_time_r,     tick_time_nxt;
  logic                   tick_seen_r,     tick_seen_nxt;

  // Working values.
  logic [MAG_W-1:0]      mag_r,     mag_nxt;
  logic                  err_neg_r, err_neg_nxt;
  logic [TIME_BITS-1:0]  dt_r,      dt_nxt;
  logic [TIME_BITS-1:0]  age_r,     age_nxt;
  logic                  expire_r,  expire_nxt;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  logic [YTC_RATE_W-1:0]  out_rate_r,  out_rate_nxt;
  logic [YTC_ANGLE_W-1:0] out_angle_r, out_angle_nxt;
  logic                   out_goal_r,  out_goal_nxt;

  // Multiplier interface.
  logic                  mul_start;
  logic [LEN_W-1:0]      mul_len;
  logic [YTC_PROD_W-1:0] mul_mcand;
  logic [TIME_BITS-1:0]  mul_mplier;
  logic                  mul_busy;
  logic [YTC_ACC_W-1:0]  mul_acc;
  logic                  mul_sat;

  // Datapath helpers.
  logic [ERR_W-1:0]         err_diff;
  logic [YTC_ACC_W-1:0]     band_lhs;
  logic [YTC_ACC_W-1:0]     gain_rnd;
  logic [YTC_ACC_W-YTC_GAIN_SHIFT-1:0] gain_v;
  logic [YTC_LIMIT_W-1:0]   rate_mag;
  logic [YTC_RATE_W-1:0]    rate_abs;
  logic                     rate_neg;
  logic                     rate_pos;
  logic [YTC_ACC_W-1:0]     step_rnd;
  logic [YTC_DELTA_W-1:0]   delta_mag;
  logic [YTC_ANG_SUM_W-1:0] ang_cur;
  logic [YTC_ANG_SUM_W-1:0] delta_ext;
  logic signed [YTC_ANG_SUM_W-1:0] ang_sum;
  logic signed [YTC_ANG_SUM_W-1:0] ang_hi;
  logic signed [YTC_ANG_SUM_W-1:0] ang_lo;

  ytc_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  ytc_serial_mult #(
    .MP_W  (TIME_BITS),
    .LEN_W (LEN_W)
  ) u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .len    (mul_len),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .busy   (mul_busy),
    .acc    (mul_acc),
    .sat    (mul_sat)
  );

  // Combinational datapath pieces used by the sequencer below.
  always_comb begin
    // Signed pixel error; its magnitude is taken in ST_PREP.
    err_diff = ERR_W'(px_r) - ERR_W'(cfg.image_center);

    // The error is outside the deadband when |err| * 2^16 exceeds the band.
    band_lhs = YTC_ACC_W'(mag_r) << 16;

    // Gain product rounded to Q8.16 and clamped to the rate limit.
    gain_rnd = mul_acc + (YTC_ACC_W'(1) << (YTC_GAIN_SHIFT - 1));
    gain_v   = gain_rnd[YTC_ACC_W-1:YTC_GAIN_SHIFT];
    if (gain_v > (YTC_ACC_W - YTC_GAIN_SHIFT)'(cfg.rate_limit)) begin
      rate_mag = cfg.rate_limit;
    end else begin
      rate_mag = gain_v[YTC_LIMIT_W-1:0];
    end

    // Current rate magnitude and sign.
    rate_neg = rate_r[YTC_RATE_W-1];
    rate_pos = !rate_neg && (rate_r != '0);
    rate_abs = rate_neg ? (~rate_r + 1'b1) : rate_r;

    // Angle step: rounded Q8.8 value, or the saturated step on overflow.
    step_rnd = mul_acc + (YTC_ACC_W'(1) << (YTC_STEP_SHIFT - 1));
    if (mul_sat) begin
      delta_mag = YTC_DELTA_W'(1) << (YTC_DELTA_W - 1);
    end else begin
      delta_mag = step_rnd[YTC_STEP_SHIFT +: YTC_DELTA_W];
    end

    ang_cur   = {{ANG_EXT_W{angle_r[YTC_ANGLE_W-1]}}, angle_r};
    delta_ext = YTC_ANG_SUM_W'(delta_mag);
    ang_sum   = rate_neg ? $signed(ang_cur - delta_ext) : $signed(ang_cur + delta_ext);
    ang_hi    = $signed(YTC_ANG_SUM_W'(cfg.angle_upper));
    ang_lo    = $signed({{(YTC_ANG_SUM_W - YTC_LOWER_W){cfg.angle_lower[YTC_LOWER_W-1]}},
                         cfg.angle_lower});
  end

  // Sequencer: next state, state updates and multiplier requests.
  always_comb begin
    state_nxt         = state_r;
    op_nxt            = op_r;
    px_nxt            = px_r;
    bw_nxt            = bw_r;
    t_nxt             = t_r;
    rate_nxt          = rate_r;
    angle_nxt         = angle_r;
    goal_nxt          = goal_r;
    sighting_time_nxt = sighting_time_r;
    tick_time_nxt     = tick_time_r;
    tick_seen_nxt     = tick_seen_r;
    mag_nxt           = mag_r;
    err_neg_nxt       = err_neg_r;
    dt_nxt            = dt_r;
    age_nxt           = age_r;
    expire_nxt        = expire_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_rate_nxt      = out_rate_r;
    out_angle_nxt     = out_angle_r;
    out_goal_nxt      = out_goal_r;
    mul_start         = 1'b0;
    mul_len           = '0;
    mul_mcand         = '0;
    mul_mplier        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          px_nxt    = in_pixel_x;
          bw_nxt    = in_box_width;
          t_nxt     = in_time_stamp;
          state_nxt = ST_PREP;
        end
      end

      ST_PREP: begin
        if (ytc_op_t'(op_r) == OP_TICK) begin
          dt_nxt    = t_r - tick_time_r;
          age_nxt   = t_r - sighting_time_r;
          state_nxt = ST_TICK;
        end else begin
          err_neg_nxt = err_diff[ERR_W-1];
          mag_nxt     = err_diff[ERR_W-1] ? MAG_W'(~err_diff + 1'b1) : MAG_W'(err_diff);
          goal_nxt          = 1'b1;
          sighting_time_nxt = t_r;
          // Deadband width: box width times ratio.
          mul_start  = 1'b1;
          mul_len    = LEN_W'(PIXEL_BITS);
          mul_mcand  = YTC_PROD_W'(cfg.deadband_ratio);
          mul_mplier = TIME_BITS'(bw_r) << (TIME_BITS - PIXEL_BITS);
          state_nxt  = ST_BAND;
        end
      end

      ST_BAND: begin
        if (!mul_busy) begin
          if (band_lhs > mul_acc) begin
            mul_start  = 1'b1;
            mul_len    = LEN_W'(MAG_W);
            mul_mcand  = YTC_PROD_W'(cfg.rate_gain);
            mul_mplier = TIME_BITS'(mag_r) << (TIME_BITS - MAG_W);
            state_nxt  = ST_GAIN;
          end else begin
            rate_nxt  = '0;
            state_nxt = ST_OUT;
          end
        end
      end

      ST_GAIN: begin
        if (!mul_busy) begin
          // The rate turns against the error.
          if (err_neg_r) begin
            rate_nxt = YTC_RATE_W'(rate_mag);
          end else begin
            rate_nxt = ~YTC_RATE_W'(rate_mag) + 1'b1;
          end
          state_nxt = ST_OUT;
        end
      end

      ST_TICK: begin
        expire_nxt = goal_r && (age_r > TIME_BITS'(cfg.goal_timeout));
        if (tick_seen_r) begin
          mul_start  = 1'b1;
          mul_len    = LEN_W'(YTC_LIMIT_W);
          mul_mcand  = YTC_PROD_W'(cfg.degree_scale);
          mul_mplier = TIME_BITS'(rate_abs[YTC_LIMIT_W-1:0]) << (TIME_BITS - YTC_LIMIT_W);
          state_nxt  = ST_STEP;
        end else begin
          state_nxt = ST_TICK_END;
        end
      end

      ST_STEP: begin
        if (!mul_busy) begin
          // Angle step per tick times the elapsed ticks.
          mul_start  = 1'b1;
          mul_len    = LEN_W'(TIME_BITS);
          mul_mcand  = mul_acc[YTC_PROD_W-1:0];
          mul_mplier = dt_r;
          state_nxt  = ST_PROD;
        end
      end

      ST_PROD: begin
        if (!mul_busy) begin
          // The upper limit wins when both limits are crossed.
          if (ang_sum >= ang_hi) begin
            angle_nxt = YTC_ANGLE_W'(cfg.angle_upper);
            if (rate_pos) begin
              rate_nxt = '0;
            end
          end else if (ang_sum <= ang_lo) begin
            angle_nxt = cfg.angle_lower;
            if (rate_neg) begin
              rate_nxt = '0;
            end
          end else begin
            angle_nxt = ang_sum[YTC_ANGLE_W-1:0];
          end
          state_nxt = ST_TICK_END;
        end
      end

      ST_TICK_END: begin
        tick_time_nxt = t_r;
        tick_seen_nxt = 1'b1;
        if (expire_r) begin
          rate_nxt = '0;
          goal_nxt = 1'b0;
        end
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rate_nxt  = rate_r;
          out_angle_nxt = angle_r;
          out_goal_nxt  = goal_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      rate_r          <= '0;
      angle_r         <= '0;
      goal_r          <= 1'b0;
      sighting_time_r <= '0;
      tick_time_r     <= '0;
      tick_seen_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      rate_r          <= rate_nxt;
      angle_r         <= angle_nxt;
      goal_r          <= goal_nxt;
      sighting_time_r <= sighting_time_nxt;
      tick_time_r     <= tick_time_nxt;
      tick_seen_r     <= tick_seen_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    px_r        <= px_nxt;
    bw_r        <= bw_nxt;
    t_r         <= t_nxt;
    mag_r       <= mag_nxt;
    err_neg_r   <= err_neg_nxt;
    dt_r        <= dt_nxt;
    age_r       <= age_nxt;
    expire_r    <= expire_nxt;
    out_rate_r  <= out_rate_nxt;
    out_angle_r <= out_angle_nxt;
    out_goal_r  <= out_goal_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_yaw_rate    = $signed(out_rate_r);
  assign out_yaw_angle   = $signed(out_angle_r);
  assign out_goal_active = out_goal_r;

endmodule

@@ sim/yaw_tracking_controller_core_tb.sv @@
// Self-checking testbench for the yaw tracking controller core with a built-in behavioral predictor.
module yaw_tracking_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ytc_pkg::*;

  localparam int TSW           = YTC_TIME_BITS_DEF;
  localparam int PXW           = YTC_PIXEL_BITS_DEF;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int TAIL_CYCLES   = 100;
  localparam int REPORT_MAX    = 10;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_REQS    = 60;

  // One request as it travels on the input channel.
  typedef struct packed {
    ytc_op_t        op;
    logic [PXW-1:0] pixel_x;
    logic [PXW-1:0] box_width;
    logic [TSW-1:0] stamp;
  } yaw_req_t;

  // The controller status that every request reports back.
  typedef struct packed {
    logic signed [YTC_RATE_W-1:0]  rate;
    logic signed [YTC_ANGLE_W-1:0] angle;
    logic                          goal;
  } yaw_status_t;

  // Ways in which the result side holds off the block.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_write_en;
  logic [YTC_CFG_IDX_W-1:0]            cfg_index;
  logic [YTC_CFG_DATA_W-1:0]           cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic                                in_operation;
  logic [PXW-1:0]                      in_pixel_x;
  logic [PXW-1:0]                      in_box_width;
  logic [TSW-1:0]                      in_time_stamp;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [YTC_RATE_W-1:0]        out_yaw_rate;
  logic signed [YTC_ANGLE_W-1:0]       out_yaw_angle;
  logic                                out_goal_active;

  // Predictor state: a private copy of the registers and of the controller state.
  ytc_cfg_t                      regs_m;
  logic signed [YTC_RATE_W-1:0]  rate_m;
  logic signed [YTC_ANGLE_W-1:0] angle_m;
  logic                          goal_m;
  logic                          tick_seen_m;
  logic [TSW-1:0]                sighted_at_m;
  logic [TSW-1:0]                ticked_at_m;

  // Requests waiting for the driver, and the statuses the block owes us, oldest first.
  yaw_req_t    req_backlog[$];
  yaw_status_t status_forecast[$];
  yaw_req_t    req_on_bus;
  yaw_status_t oldest_status;

  int          errors;
  int          burst_left;
  int          gap_left;
  stall_mode_t stall_mode;
  int          mode_left;
  int          stall_phase;
  int          cycle_count;

  yaw_tracking_controller_core #(
    .TIME_BITS (TSW),
    .PIXEL_BITS(PXW)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_pixel_x     (in_pixel_x),
    .in_box_width   (in_box_width),
    .in_time_stamp  (in_time_stamp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_yaw_rate   (out_yaw_rate),
    .out_yaw_angle  (out_yaw_angle),
    .out_goal_active(out_goal_active)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Advances the predicted controller by one accepted request and queues the status it
  // must report. A sighting sets the rate from the pixel error unless the error sits
  // inside the deadband; a tick integrates the angle, clamps it and retires a stale goal.
  task automatic update_yaw_model(input yaw_req_t r);
    logic signed [PXW+1:0]             err;
    logic [PXW:0]                      err_mag;
    logic [PXW+YTC_RATIO_W-1:0]        band;
    logic [YTC_GAIN_W+PXW+1:0]         rate_mag;
    logic [TSW-1:0]                    elapsed;
    logic [YTC_RATE_W-1:0]             rmag;
    logic [YTC_RATE_W+YTC_SCALE_W-1:0] step_q48;
    logic [127:0]                      travel;
    longint                            delta;
    longint                            next_angle;
    longint                            upper_l;
    longint                            lower_l;
    if (r.op == OP_SIGHTING) begin
      err = $signed({2'b00, r.pixel_x}) - $signed({2'b00, regs_m.image_center});
      err_mag = err[PXW+1] ? -err : err;
      band = r.box_width * regs_m.deadband_ratio;
      rate_m = '0;
      if ({err_mag, 16'b0} > band) begin
        rate_mag = regs_m.rate_gain * err_mag + 128;
        rate_mag = rate_mag >> YTC_GAIN_SHIFT;
        if (rate_mag > regs_m.rate_limit) begin
          rate_mag = regs_m.rate_limit;
        end
        rate_m = rate_mag[YTC_RATE_W-1:0];
        // The command turns against the error.
        if (err > 0) begin
          rate_m = -rate_m;
        end
      end
      goal_m = 1'b1;
      sighted_at_m = r.stamp;
    end else begin
      // The very first tick records its time stamp without moving the angle.
      if (tick_seen_m) begin
        elapsed = r.stamp - ticked_at_m;
        rmag = rate_m[YTC_RATE_W-1] ? -rate_m : rate_m;
        step_q48 = rmag * regs_m.degree_scale;
        travel = 128'(step_q48) * 128'(elapsed);
        // Past the product cap the step saturates beyond any reachable limit.
        if (travel > YTC_PROD_CAP) begin
          delta = longint'(1) << (YTC_DELTA_W - 1);
        end else begin
          travel = (travel + (128'd1 << (YTC_STEP_SHIFT - 1))) >> YTC_STEP_SHIFT;
          delta = travel[63:0];
        end
        if (rate_m < 0) begin
          delta = -delta;
        end
        next_angle = angle_m + delta;
        upper_l = regs_m.angle_upper;
        lower_l = $signed(regs_m.angle_lower);
        // The upper limit wins when both limits are hit at once.
        if (next_angle >= upper_l) begin
          next_angle = upper_l;
          if (rate_m > 0) begin
            rate_m = '0;
          end
        end else if (next_angle <= lower_l) begin
          next_angle = lower_l;
          if (rate_m < 0) begin
            rate_m = '0;
          end
        end
        angle_m = next_angle[YTC_ANGLE_W-1:0];
      end
      ticked_at_m = r.stamp;
      tick_seen_m = 1'b1;
      elapsed = r.stamp - sighted_at_m;
      if (goal_m && elapsed > regs_m.goal_timeout) begin
        rate_m = '0;
        goal_m = 1'b0;
      end
    end
    status_forecast.push_back('{rate: rate_m, angle: angle_m, goal: goal_m});
  endtask

  task automatic push_req(input ytc_op_t op, input logic [PXW-1:0] px,
                          input logic [PXW-1:0] bw, input logic [TSW-1:0] stamp);
    req_backlog.push_back('{op: op, pixel_x: px, box_width: bw, stamp: stamp});
  endtask

  // Time stamp advance between requests: mostly small and medium steps, with zero steps,
  // steps past the reset timeout, wild jumps and steps backwards mixed in.
  function automatic logic [TSW-1:0] stamp_step();
    case ($urandom_range(0, 15))
      0:                   return '0;
      1, 2, 3, 4, 5, 6, 7: return $urandom_range(1, 2000);
      8, 9, 10, 11:        return $urandom_range(2000, 400000);
      12, 13:              return $urandom_range(0, 5000000);
      14:                  return TSW'({$urandom, $urandom});
      default:             return -TSW'($urandom_range(1, 5000));
    endcase
  endfunction

  // The block is idle once nothing waits to be sent and every status has come back.
  task automatic wait_for_idle();
    while (req_backlog.size() != 0 || in_valid || status_forecast.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Request driver. The sender runs in bursts of random length separated by random
  // gaps; now and then a long burst with no gap at all goes through. The predictor
  // steps at the edge where the block takes a request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        update_yaw_model(req_on_bus);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          req_on_bus = req_backlog.pop_front();
          in_valid <= 1'b1;
          in_operation <= req_on_bus.op;
          in_pixel_x <= req_on_bus.pixel_x;
          in_box_width <= req_on_bus.box_width;
          in_time_stamp <= req_on_bus.stamp;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver. Every status taken from the block is checked against
  // the oldest prediction. The stall pattern switches between no stall, light and heavy
  // random stalls and a fixed duty cycle, each held for a random stretch.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (status_forecast.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("unexpected status: rate %0d angle %0d goal %0b",
                     out_yaw_rate, out_yaw_angle, out_goal_active);
          end
        end else begin
          oldest_status = status_forecast.pop_front();
          if (oldest_status.rate !== out_yaw_rate || oldest_status.angle !== out_yaw_angle ||
              oldest_status.goal !== out_goal_active) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("status mismatch: rate exp %0d got %0d, angle exp %0d got %0d, goal exp %0b got %0b",
                       oldest_status.rate, out_yaw_rate, oldest_status.angle, out_yaw_angle,
                       oldest_status.goal, out_goal_active);
            end
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_phase % 8) < 5);
      endcase
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    ytc_cfg_t            plan;
    ytc_cfg_idx_t        ridx;
    logic [YTC_CFG_DATA_W-1:0] rdata;
    logic [TSW-1:0]      now_ts;
    int                  span;
    int                  made;
    int                  ticks;
    rst_n = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_pixel_x = '0;
    in_box_width = '0;
    in_time_stamp = '0;
    out_stall = 1'b0;
    errors = 0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = STALL_NONE;
    mode_left = 0;
    stall_phase = 0;
    cycle_count = 0;
    regs_m = '{image_center:   YTC_CENTER_RST,
               deadband_ratio: YTC_RATIO_RST,
               rate_gain:      YTC_GAIN_RST,
               rate_limit:     YTC_LIMIT_RST,
               angle_upper:    YTC_UPPER_RST,
               angle_lower:    YTC_LOWER_RST,
               goal_timeout:   YTC_TIMEOUT_RST,
               degree_scale:   YTC_SCALE_RST};
    rate_m = '0;
    angle_m = '0;
    goal_m = 1'b0;
    tick_seen_m = 1'b0;
    sighted_at_m = '0;
    ticked_at_m = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset register values. The first tick only records
    // its time. Then come pixel extremes, an error of zero, targets inside the deadband,
    // a step of zero ticks, a goal exactly at its timeout and one tick past it, steps
    // large enough to saturate the product into each angle limit, time stamps that
    // wrap forward through the top of the counter, and one that runs backwards.
    push_req(OP_TICK, 0, 0, 48'd100);
    push_req(OP_SIGHTING, 0, 0, 48'd100);
    push_req(OP_TICK, 4095, 4095, 48'd1100);
    push_req(OP_TICK, 0, 0, 48'd1100);
    push_req(OP_SIGHTING, 4095, 4095, 48'd1200);
    push_req(OP_TICK, 0, 0, 48'd3000);
    push_req(OP_SIGHTING, 330, 200, 48'd3000);
    push_req(OP_SIGHTING, 320, 0, 48'd3000);
    push_req(OP_SIGHTING, 0, 4095, 48'd3000);
    push_req(OP_SIGHTING, 100, 0, 48'd3000);
    push_req(OP_TICK, 0, 0, 48'd503000);
    push_req(OP_TICK, 0, 0, 48'd503001);
    push_req(OP_SIGHTING, 0, 0, 48'd503001);
    push_req(OP_TICK, 0, 0, 48'd503001 + (48'd1 << 40));
    push_req(OP_SIGHTING, 4095, 0, 48'd503001 + (48'd1 << 40));
    push_req(OP_TICK, 0, 0, 48'd503001 + (48'd3 << 40));
    push_req(OP_TICK, 0, 0, 48'hFFFF_FFFF_FF00);
    push_req(OP_SIGHTING, 640, 0, 48'hFFFF_FFFF_FF00);
    push_req(OP_TICK, 0, 0, 48'h80);
    push_req(OP_TICK, 0, 0, 48'h10);
    push_req(OP_SIGHTING, 1234, 50, 48'hFFFF_FFFF_FFFF);
    push_req(OP_TICK, 0, 0, 48'h0);
    wait_for_idle();

    now_ts = TSW'({$urandom, $urandom});
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // The first two settings pin every register to one end of its range; the rest
      // are random, biased toward small values so that limits and timeouts come into play.
      case (ph)
        0: begin
          plan = '{image_center: '0, deadband_ratio: '0, rate_gain: '1, rate_limit: '1,
                   angle_upper: '1, angle_lower: 16'sh8000, goal_timeout: '1,
                   degree_scale: '1};
        end
        1: begin
          plan = '{image_center: '1, deadband_ratio: '1, rate_gain: '0, rate_limit: '0,
                   angle_upper: '0, angle_lower: '0, goal_timeout: '0, degree_scale: '0};
        end
        default: begin
          plan.image_center = $urandom_range(0, (1 << YTC_CENTER_W) - 1);
          plan.deadband_ratio = $urandom >> $urandom_range(16, 31);
          plan.rate_gain = $urandom >> $urandom_range(8, 31);
          plan.rate_limit = $urandom >> $urandom_range(9, 31);
          plan.angle_upper = $urandom >> $urandom_range(17, 31);
          span = $urandom_range(0, 32768) >> $urandom_range(0, 12);
          plan.angle_lower = -span;
          plan.goal_timeout = $urandom >> $urandom_range(0, 31);
          plan.degree_scale = $urandom >> $urandom_range(0, 28);
        end
      endcase

      // The block is idle here, so all registers are rewritten back to back.
      for (int i = 0; i < (1 << YTC_CFG_IDX_W); i++) begin
        ridx = ytc_cfg_idx_t'(i);
        case (ridx)
          CFG_IMAGE_CENTER:   rdata = plan.image_center;
          CFG_DEADBAND_RATIO: rdata = plan.deadband_ratio;
          CFG_RATE_GAIN:      rdata = plan.rate_gain;
          CFG_RATE_LIMIT:     rdata = plan.rate_limit;
          CFG_ANGLE_UPPER:    rdata = plan.angle_upper;
          CFG_ANGLE_LOWER:    rdata = plan.angle_lower;
          CFG_GOAL_TIMEOUT:   rdata = plan.goal_timeout;
          default:            rdata = plan.degree_scale;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= ridx;
        cfg_data <= rdata;
      end
      @(posedge clk);
      cfg_write_en <= 1'b0;
      regs_m = plan;

      // Most traffic is tracking episodes: a sighting near the image center followed by
      // a few control ticks. The rest is noise with fully random fields and time stamps.
      made = 0;
      while (made < PHASE_REQS) begin
        if ($urandom_range(0, 6) == 0) begin
          push_req(ytc_op_t'($urandom_range(0, 1)), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), TSW'({$urandom, $urandom}));
          made++;
        end else begin
          span = 1 << $urandom_range(0, PXW - 1);
          now_ts += stamp_step();
          push_req(OP_SIGHTING, regs_m.image_center + $urandom_range(0, 2 * span) - span,
                   $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 64),
                   now_ts);
          made++;
          ticks = $urandom_range(0, 5);
          repeat (ticks) begin
            now_ts += stamp_step();
            push_req(OP_TICK, $urandom_range(0, 4095), $urandom_range(0, 4095), now_ts);
            made++;
          end
        end
      end
      wait_for_idle();
    end

    // Let any stray status surface before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && status_forecast.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
